// ===== rtl/core/profile_slot_allocator_assert.svh =====
// Assertion macros for the checker file of the slot allocator.
`ifndef PROFILE_SLOT_ALLOCATOR_ASSERT_SVH
`define PROFILE_SLOT_ALLOCATOR_ASSERT_SVH

// Plain property, checked at every clock edge outside reset.
`define PSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define PSA_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and codes of the profile slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int ID_W    = 11;
   localparam int ST_W    = 3;
   localparam int CFG_W   = 12;
   localparam int MAP_BITS = 32;
   localparam int CAP_LIMIT = 2048;
   localparam int QUEUE_DEPTH = 4;
   localparam int QP_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
   localparam logic [ST_W-1:0] ST_ZERO    = 3'd2;
   localparam logic [ST_W-1:0] ST_ALREADY = 3'd3;
   localparam logic [ST_W-1:0] ST_NEVER   = 3'd4;
   localparam logic [ST_W-1:0] ST_BUSY    = 3'd5;

   // Classified operation handed from front to back.
   typedef enum logic [2:0] {
      OP_FIRST,
      OP_BYTE,
      OP_LAST,
      OP_BUSY,
      OP_REMOVE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  data_byte;
      logic [ID_W-1:0]    slot_id;
      logic [BYTE_W-1:0]  byte_index;
   } entry_type;

endpackage

// ===== rtl/core/profile_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// profile_slot_allocator
// Pool of fixed-size profile slots with reuse of the highest freed id.
//
//   channel   dir   handshake              payload
//   req_      in    tvalid/tready          tuser command, tdata bytes and ids
//   rsp_      out   tvalid/tready          tuser status, tdata id and byte
//   csr_      in    we                     max_entries
//
// Add bytes are stored one per cycle while queued; the first byte of a run
// passes B_FIND when a freed id is reused (summary lookup, then map word).
// Remove reads the free map, then updates it in B_RMCHK; read waits in
// B_RDWAIT for the registered store read data. A four-entry queue separates
// front and back. Reset is synchronous; no clearing pass, the free map is
// qualified by a per-word summary register. A stalled result holds the back;
// the front keeps accepting until the queue fills, then drops req_tready.
// ----------------------------------------------------------------------------
module profile_slot_allocator
   import psa_pkg::*;
#(
   parameter int MAX_SLOTS  = 2048,
   parameter int SLOT_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // data_byte[7:0], slot_id[18:8], byte_index[26:19]
   input  logic [1:0]        req_tuser,   // command[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // result_id[10:0], read_byte[18:11]
   output logic [2:0]        rsp_tuser,   // status[2:0]
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_wdata
);

   entry_type         push_entry, head_entry;
   logic              q_full, q_push, q_pop, q_valid;
   logic [ID_W-1:0]   result_id;
   logic [ST_W-1:0]   status;
   logic [BYTE_W-1:0] read_byte;

   psa_front #(
      .SLOT_BYTES (SLOT_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_command    (req_tuser),
      .req_data_byte  (req_tdata[7:0]),
      .req_slot_id    (req_tdata[18:8]),
      .req_byte_index (req_tdata[26:19]),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   psa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   psa_back #(
      .MAX_SLOTS  (MAX_SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .head_valid    (q_valid),
      .head_entry    (head_entry),
      .pop           (q_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_result_id (result_id),
      .rsp_status    (status),
      .rsp_read_byte (read_byte)
   );

   // Pack the result
   assign rsp_tdata = {5'd0, read_byte, result_id};
   assign rsp_tuser = status;

endmodule

// ===== rtl/core/psa_ram.sv =====
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and hold read data until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/psa_front.sv =====
// ----------------------------------------------------------------------------
// psa_front
// Accepts requests, tracks the add run and classifies each request.
// ----------------------------------------------------------------------------
module psa_front
   import psa_pkg::*;
#(
   parameter int SLOT_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [ID_W-1:0]     req_slot_id,
   input  logic [BYTE_W-1:0]   req_byte_index,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   localparam int PW = $clog2(SLOT_BYTES);

   logic [PW-1:0] count_ff, count_in;
   logic          accept;
   logic          in_run;
   logic          keep;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign in_run     = (count_ff != '0);

   // Classify the request against the add run
   always_comb begin
      q_entry.data_byte  = req_data_byte;
      q_entry.slot_id    = req_slot_id;
      q_entry.byte_index = req_byte_index;
      q_entry.op         = OP_BUSY;
      keep               = 1'b1;
      count_in           = count_ff;
      if (req_command == CMD_ADD) begin
         if (!in_run) begin
            q_entry.op = OP_FIRST;
            count_in   = PW'(1);
         end else if (count_ff == PW'(SLOT_BYTES - 1)) begin
            q_entry.op = OP_LAST;
            count_in   = '0;
         end else begin
            q_entry.op = OP_BYTE;
            count_in   = count_ff + PW'(1);
         end
      end else if (in_run) begin
         q_entry.op = OP_BUSY;
      end else if (req_command == CMD_REMOVE) begin
         q_entry.op = OP_REMOVE;
      end else if (req_command == CMD_READ) begin
         q_entry.op = OP_READ;
      end else begin
         keep = 1'b0;
      end
   end

   assign q_push = accept && keep;

   // Advance the byte position of the run
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/psa_queue.sv =====
// ----------------------------------------------------------------------------
// psa_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module psa_queue
   import psa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type       slots_ff [QUEUE_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QP_W:0]   fill_ff;
   logic            do_pop;

   assign full       = (fill_ff == (QP_W+1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QP_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QP_W'(1);
         end
         if (push && !do_pop) begin
            fill_ff <= fill_ff + (QP_W+1)'(1);
         end else if (do_pop && !push) begin
            fill_ff <= fill_ff - (QP_W+1)'(1);
         end
      end
   end

endmodule

// ===== rtl/core/psa_back.sv =====
// ----------------------------------------------------------------------------
// psa_back
// Carries out classified requests: allocation, byte store, remove, read.
// ----------------------------------------------------------------------------
module psa_back
   import psa_pkg::*;
#(
   parameter int MAX_SLOTS  = 2048,
   parameter int SLOT_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              head_valid,
   input  entry_type         head_entry,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic [ST_W-1:0]   rsp_status,
   output logic [BYTE_W-1:0] rsp_read_byte
);

   localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int NW    = $clog2(MAX_SLOTS + 1);
   localparam int PW    = $clog2(SLOT_BYTES);
   localparam int WORDS = (MAX_SLOTS + MAP_BITS - 1) / MAP_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BW    = $clog2(MAP_BITS);
   localparam int DEPTH = MAX_SLOTS * SLOT_BYTES;
   localparam int SAW   = $clog2(DEPTH);
   localparam int CAP_RESET = (CAP_LIMIT < MAX_SLOTS) ? CAP_LIMIT : MAX_SLOTS;

   typedef enum logic [1:0] {
      B_EXEC,
      B_FIND,
      B_RMCHK,
      B_RDWAIT
   } state_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     slot_ff, slot_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              failed_ff, failed_in;
   logic [NW-1:0]     next_ff, next_in;
   logic [NW-1:0]     cap_ff;
   logic [WORDS-1:0]  summ_ff, summ_in;
   logic              rvalid_ff, rvalid_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic [ST_W-1:0]   rst_ff, rst_in;
   logic [BYTE_W-1:0] rbyte_ff, rbyte_in;

   logic              out_free;
   logic              st_we, st_re;
   logic [SAW-1:0]    st_waddr, st_raddr;
   logic [BYTE_W-1:0] st_wdata, st_rdata;
   logic              fm_we, fm_re;
   logic [WAW-1:0]    fm_waddr, fm_raddr;
   logic [MAP_BITS-1:0] fm_wdata, fm_rdata;

   logic [WAW-1:0]    top_word;
   logic [BW-1:0]     top_bit;
   logic [WAW+BW-1:0] found_id;
   logic [MAP_BITS-1:0] word_cur;
   logic              id_fits;
   logic [IW-1:0]     id_cut;
   logic [WAW-1:0]    id_word;
   logic [BW-1:0]     id_bit;
   logic              rd_trivial;

   // Capacity: max_entries rounded up to a power of two, capped
   function automatic logic [12:0] cap_of(input logic [CFG_W-1:0] me);
      logic [12:0]      p;
      logic [CFG_W-1:0] m1;
      p  = 13'd1;
      m1 = me - CFG_W'(1);
      if (me > CFG_W'(1)) begin
         for (int i = 0; i < CFG_W; i++) begin
            if (m1[i]) begin
               p = 13'd2 << i;
            end
         end
      end
      if (p > 13'(CAP_RESET)) begin
         p = 13'(CAP_RESET);
      end
      return p;
   endfunction

   // Highest set bit of the summary word
   always_comb begin
      top_word = '0;
      for (int i = 0; i < WORDS; i++) begin
         if (summ_ff[i]) begin
            top_word = WAW'(i);
         end
      end
   end

   // Highest set bit of the fetched free word
   always_comb begin
      top_bit = '0;
      for (int i = 0; i < MAP_BITS; i++) begin
         if (fm_rdata[i]) begin
            top_bit = BW'(i);
         end
      end
   end

   assign found_id   = {top_word, top_bit};
   assign id_fits    = ({21'd0, head_entry.slot_id} < 32'(MAX_SLOTS));
   assign id_cut     = IW'(head_entry.slot_id);
   assign id_word    = WAW'(id_cut >> BW);
   assign id_bit     = BW'(id_cut);
   assign word_cur   = summ_ff[id_word] ? fm_rdata : '0;
   assign rd_trivial = (head_entry.slot_id == '0) || !id_fits ||
                       ({2'd0, head_entry.byte_index} >= 10'(SLOT_BYTES));
   assign out_free   = !rvalid_ff || rsp_tready;

   // Sequence each queued operation
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      pos_in    = pos_ff;
      failed_in = failed_ff;
      next_in   = next_ff;
      summ_in   = summ_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rid_in    = rid_ff;
      rst_in    = rst_ff;
      rbyte_in  = rbyte_ff;
      pop       = 1'b0;
      st_we     = 1'b0;
      st_waddr  = SAW'(slot_ff) * SAW'(SLOT_BYTES) + SAW'(pos_ff);
      st_wdata  = head_entry.data_byte;
      st_re     = 1'b0;
      st_raddr  = SAW'(id_cut) * SAW'(SLOT_BYTES) + SAW'(head_entry.byte_index);
      fm_we     = 1'b0;
      fm_waddr  = id_word;
      fm_wdata  = word_cur | (MAP_BITS'(1) << id_bit);
      fm_re     = 1'b0;
      fm_raddr  = id_word;
      unique case (state_ff)
         B_EXEC: begin
            if (head_valid) begin
               unique case (head_entry.op)
                  OP_FIRST: begin
                     if (summ_ff != '0) begin
                        fm_re    = 1'b1;
                        fm_raddr = top_word;
                        state_in = B_FIND;
                     end else begin
                        failed_in = (next_ff >= cap_ff);
                        slot_in   = failed_in ? '0 : IW'(next_ff);
                        if (!failed_in) begin
                           next_in = next_ff + NW'(1);
                        end
                        st_we    = !failed_in;
                        st_waddr = SAW'(slot_in) * SAW'(SLOT_BYTES);
                        pos_in   = PW'(1);
                        pop      = 1'b1;
                     end
                  end
                  OP_BYTE: begin
                     st_we  = !failed_ff;
                     pos_in = pos_ff + PW'(1);
                     pop    = 1'b1;
                  end
                  OP_LAST: begin
                     if (out_free) begin
                        st_we     = !failed_ff;
                        pos_in    = '0;
                        failed_in = 1'b0;
                        rvalid_in = 1'b1;
                        rid_in    = failed_ff ? '0 : ID_W'(slot_ff);
                        rst_in    = failed_ff ? ST_FULL : ST_OK;
                        rbyte_in  = '0;
                        pop       = 1'b1;
                     end
                  end
                  OP_BUSY: begin
                     if (out_free) begin
                        rvalid_in = 1'b1;
                        rid_in    = head_entry.slot_id;
                        rst_in    = ST_BUSY;
                        rbyte_in  = '0;
                        pop       = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (head_entry.slot_id == '0 ||
                         {2'd0, head_entry.slot_id} >= 13'(next_ff) || !id_fits) begin
                        if (out_free) begin
                           rvalid_in = 1'b1;
                           rid_in    = head_entry.slot_id;
                           rst_in    = (head_entry.slot_id == '0) ? ST_ZERO : ST_NEVER;
                           rbyte_in  = '0;
                           pop       = 1'b1;
                        end
                     end else begin
                        fm_re    = 1'b1;
                        state_in = B_RMCHK;
                     end
                  end
                  OP_READ: begin
                     if (rd_trivial) begin
                        if (out_free) begin
                           rvalid_in = 1'b1;
                           rid_in    = head_entry.slot_id;
                           rst_in    = ST_OK;
                           rbyte_in  = '0;
                           pop       = 1'b1;
                        end
                     end else begin
                        st_re    = 1'b1;
                        state_in = B_RDWAIT;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         B_FIND: begin
            // Take the highest free id and clear its bit
            fm_we     = 1'b1;
            fm_waddr  = top_word;
            fm_wdata  = fm_rdata & ~(MAP_BITS'(1) << top_bit);
            if (fm_wdata == '0) begin
               summ_in[top_word] = 1'b0;
            end
            slot_in   = IW'(found_id);
            failed_in = 1'b0;
            st_we     = 1'b1;
            st_waddr  = SAW'(slot_in) * SAW'(SLOT_BYTES);
            pos_in    = PW'(1);
            pop       = 1'b1;
            state_in  = B_EXEC;
         end
         B_RMCHK: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               rid_in    = head_entry.slot_id;
               rbyte_in  = '0;
               if (word_cur[id_bit]) begin
                  rst_in = ST_ALREADY;
               end else begin
                  rst_in           = ST_OK;
                  fm_we            = 1'b1;
                  summ_in[id_word] = 1'b1;
               end
               pop      = 1'b1;
               state_in = B_EXEC;
            end
         end
         B_RDWAIT: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               rid_in    = head_entry.slot_id;
               rst_in    = ST_OK;
               rbyte_in  = st_rdata;
               pop       = 1'b1;
               state_in  = B_EXEC;
            end
         end
         default: begin
            state_in = B_EXEC;
         end
      endcase
   end

   // Hold state, allocator registers and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_EXEC;
         slot_ff   <= '0;
         pos_ff    <= '0;
         failed_ff <= 1'b0;
         next_ff   <= NW'(1);
         cap_ff    <= NW'(CAP_RESET);
         summ_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         pos_ff    <= pos_in;
         failed_ff <= failed_in;
         next_ff   <= next_in;
         summ_ff   <= summ_in;
         rvalid_ff <= rvalid_in;
         if (csr_we) begin
            cap_ff <= NW'(cap_of(csr_wdata));
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rid_ff   <= rid_in;
      rst_ff   <= rst_in;
      rbyte_ff <= rbyte_in;
   end

   assign rsp_tvalid    = rvalid_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_status    = rst_ff;
   assign rsp_read_byte = rbyte_ff;

   psa_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   psa_ram #(
      .WIDTH (MAP_BITS),
      .DEPTH (1 << WAW)
   ) u_free_map (
      .clock   (clock),
      .wr_en   (fm_we),
      .wr_addr (fm_waddr),
      .wr_data (fm_wdata),
      .rd_en   (fm_re),
      .rd_addr (fm_raddr),
      .rd_data (fm_rdata)
   );

endmodule

// ===== rtl/core/psa_checker.sv =====
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks on the slot allocator results.
// ----------------------------------------------------------------------------
`include "profile_slot_allocator_assert.svh"

module psa_checker
   import psa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   `PSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `PSA_ASSERT(a_status_code, clock, reset, !rsp_tvalid || rsp_tuser <= ST_BUSY, "status code out of range")
   `PSA_ASSERT(a_byte_only_ok, clock, reset, !rsp_tvalid || rsp_tuser == ST_OK || rsp_tdata[18:11] == 8'd0, "read byte set on a failed result")
   `PSA_ASSERT(a_full_id_zero, clock, reset, !rsp_tvalid || rsp_tuser != ST_FULL || rsp_tdata[10:0] == 11'd0, "pool full with nonzero id")

endmodule

bind profile_slot_allocator psa_checker u_psa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/profile_slot_allocator_test.sv =====
// ----------------------------------------------------------------------------
// profile_slot_allocator_test
// Self-checking bench for the profile slot allocator. Requests are queued by
// a stimulus process, driven by a clocked driver with random idle cycles and
// predicted on acceptance; a clocked monitor compares every response with the
// oldest predicted one. Phases change max_entries while the block is idle.
// ----------------------------------------------------------------------------
module profile_slot_allocator_test;
   import psa_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
   localparam int SLOTS     = 2048;
   localparam int PROF_BYTES = 256;
   localparam int DRAIN_CYCLES = 20;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 200;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data;
      logic [ID_W-1:0]   id;
      logic [BYTE_W-1:0] bidx;
   } request_t;

   typedef struct {
      logic [ID_W-1:0]   id;
      logic [ST_W-1:0]   status;
      logic [BYTE_W-1:0] rbyte;
   } response_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;   // data_byte[7:0], slot_id[18:8], byte_index[26:19]
   logic [1:0]        req_tuser = '0;   // command[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;        // result_id[10:0], read_byte[18:11]
   logic [2:0]        rsp_tuser;        // status[2:0]
   logic              csr_we = 1'b0;
   logic [CFG_W-1:0]  csr_wdata = '0;

   request_t  pending_q[$];
   response_t expected_q[$];
   int        errors = 0;
   int        responses_seen = 0;
   bit        no_idle = 1'b0;

   // Allocator shadow state
   logic [CFG_W-1:0] max_entries = 12'd2048;
   int               next_free_id = 1;
   bit               released[SLOTS];
   logic [7:0]       profile_mem[int];
   bit               run_active = 0;
   int               run_slot = 0;
   int               run_count = 0;
   bit               run_full = 0;

   profile_slot_allocator uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pool_capacity();
      int p;
      p = 1;
      while (p < max_entries && p < CAP_LIMIT) p = p << 1;
      if (p > CAP_LIMIT) p = CAP_LIMIT;
      return p;
   endfunction

   function automatic void push_response(int id, logic [ST_W-1:0] st, logic [7:0] b);
      response_t r;
      r.id = id[ID_W-1:0];
      r.status = st;
      r.rbyte = b;
      expected_q.push_back(r);
   endfunction

   // Advance the allocator shadow by one accepted request.
   function automatic void apply_request(request_t rq);
      int i;
      int key;
      logic [7:0] b;
      if (rq.cmd == CMD_ADD) begin
         if (!run_active) begin
            run_full = 1;
            run_slot = 0;
            for (i = SLOTS - 1; i > 0; i--) begin
               if (released[i]) begin
                  released[i] = 0;
                  run_slot = i;
                  run_full = 0;
                  break;
               end
            end
            if (run_full && next_free_id < pool_capacity()) begin
               run_slot = next_free_id;
               next_free_id++;
               run_full = 0;
            end
            run_active = 1;
            run_count = 0;
         end
         if (!run_full) profile_mem[run_slot * PROF_BYTES + run_count] = rq.data;
         run_count++;
         if (run_count >= PROF_BYTES) begin
            run_active = 0;
            run_count = 0;
            push_response(run_full ? 0 : run_slot, run_full ? ST_FULL : ST_OK, 8'd0);
            run_full = 0;
         end
      end else if (run_active) begin
         push_response(rq.id, ST_BUSY, 8'd0);
      end else if (rq.cmd == CMD_REMOVE) begin
         if (rq.id == 0) push_response(rq.id, ST_ZERO, 8'd0);
         else if (rq.id >= next_free_id) push_response(rq.id, ST_NEVER, 8'd0);
         else if (released[rq.id]) push_response(rq.id, ST_ALREADY, 8'd0);
         else begin
            released[rq.id] = 1;
            push_response(rq.id, ST_OK, 8'd0);
         end
      end else if (rq.cmd == CMD_READ) begin
         key = rq.id * PROF_BYTES + rq.bidx;
         b = (rq.id != 0 && profile_mem.exists(key)) ? profile_mem[key] : 8'd0;
         push_response(rq.id, ST_OK, b);
      end
   endfunction

   // Driver: hold an offered request until accepted, idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(pending_q.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_q[0].cmd;
               req_tdata  <= {5'd0, pending_q[0].bidx, pending_q[0].id, pending_q[0].data};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare responses in order, stall at random, one long hold-off.
   int  hold_left = 0;
   bit  hold_done = 0;
   always @(posedge clock) begin
      response_t e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response id %0d status %0d byte %0d", $realtime,
                        rsp_tdata[10:0], rsp_tuser, rsp_tdata[18:11]);
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata[10:0] !== e.id) begin
                  errors++;
                  $display("%0t: result_id expected %0d actual %0d", $realtime, e.id,
                           rsp_tdata[10:0]);
               end
               if (rsp_tuser !== e.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                           rsp_tuser);
               end
               if (rsp_tdata[18:11] !== e.rbyte) begin
                  errors++;
                  $display("%0t: read_byte expected %0d actual %0d", $realtime, e.rbyte,
                           rsp_tdata[18:11]);
               end
            end
         end
         if (!hold_done && responses_seen >= 30) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || $urandom_range(99) >= 10;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   int stall_count = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("profile_slot_allocator: mismatch");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   function automatic request_t make_request(logic [1:0] c, int d, int id, int bi);
      request_t r;
      r.cmd = c;
      r.data = d[7:0];
      r.id = id[ID_W-1:0];
      r.bidx = bi[7:0];
      return r;
   endfunction

   function automatic request_t random_misc(int readable);
      int pick;
      int hi;
      pick = $urandom_range(99);
      hi = (readable + 2 > 2047) ? 2047 : readable + 2;
      if (pick < 45)
         return make_request(CMD_REMOVE, $urandom_range(255),
                             $urandom_range(1) ? $urandom_range(hi) : $urandom_range(2047),
                             $urandom_range(255));
      if (pick < 90)
         return make_request(CMD_READ, $urandom_range(255), $urandom_range(readable - 1),
                             $urandom_range(255));
      return make_request(CMD_NOP, $urandom_range(255), $urandom_range(2047),
                          $urandom_range(255));
   endfunction

   // Queue misc requests around full add runs, with busy commands inside runs.
   task automatic queue_phase(int n_misc, int n_runs);
      int readable;
      int r;
      int k;
      int b;
      readable = next_free_id;
      for (r = 0; r <= n_runs; r++) begin
         for (k = 0; k < n_misc / (n_runs + 1); k++)
            pending_q.push_back(random_misc(readable));
         if (r == n_runs) break;
         for (b = 0; b < PROF_BYTES; b++) begin
            if (b > 0 && $urandom_range(99) < 6)
               pending_q.push_back(make_request($urandom_range(3, 1), $urandom_range(255),
                                                $urandom_range(2047), $urandom_range(255)));
            pending_q.push_back(make_request(CMD_ADD, $urandom_range(255),
                                             $urandom_range(2047), $urandom_range(255)));
         end
      end
   endtask

   // Wait for the block to drain, then write the capacity register.
   task automatic set_capacity(logic [CFG_W-1:0] v);
      while (pending_q.size() != 0 || expected_q.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      max_entries = v;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero id, never-allocated ids, reserved slot reads, ignored command
      set_capacity(12'd2048);
      pending_q.push_back(make_request(CMD_REMOVE, 0, 0, 0));
      pending_q.push_back(make_request(CMD_REMOVE, 255, 2047, 255));
      pending_q.push_back(make_request(CMD_REMOVE, 0, 1, 0));
      pending_q.push_back(make_request(CMD_READ, 255, 0, 255));
      pending_q.push_back(make_request(CMD_READ, 0, 0, 0));
      pending_q.push_back(make_request(CMD_NOP, 255, 2047, 255));
      pending_q.push_back(make_request(CMD_NOP, 0, 0, 0));

      // Small pool: one allocation succeeds
      set_capacity(12'd2);
      queue_phase(40, 1);
      // Capacity one: add fails when nothing is free
      set_capacity(12'd0);
      queue_phase(40, 1);
      // Largest value: removes, reads and ignored commands only
      set_capacity(12'hFFF);
      queue_phase(40, 0);
      // No idle stretch on either side
      set_capacity(12'd3);
      no_idle = 1'b1;
      queue_phase(40, 1);
      set_capacity(12'd1);
      no_idle = 1'b0;
      queue_phase(40, 0);
      set_capacity(12'd2048);
      queue_phase(40, 0);

      while (pending_q.size() != 0 || expected_q.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("profile_slot_allocator: match");
      else
         $display("profile_slot_allocator: mismatch");
      $finish;
   end

endmodule
